/* rtl/core/bdq_pkg.sv */
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared types and constants of the bounded deque store: default sizes,
// stream field widths, command and status codes, cell control.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int CAPACITY_DEF      = 256;
    localparam int ELEMENT_WIDTH_DEF = 32;

    localparam int CMD_W     = 3;
    localparam int ELEM_W    = 32;
    localparam int POS_W     = 8;
    localparam int VALUE_W   = 32;
    localparam int COUNT_W   = 9;
    localparam int STATUS_W  = 2;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_HEAD = 3'd0,
        CMD_INS_TAIL = 3'd1,
        CMD_REM_HEAD = 3'd2,
        CMD_REM_TAIL = 3'd3,
        CMD_RD_HEAD  = 3'd4,
        CMD_RD_TAIL  = 3'd5,
        CMD_RD_INDEX = 3'd6,
        CMD_NOP      = 3'd7
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT_UP,
        CELL_SHIFT_DOWN,
        CELL_WRITE
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     tap_load;
        logic     tap_shift;
    } t_cell_ctrl;

endpackage

/* rtl/core/bounded_deque_store_unit.sv */
// ----------------------------------------------------------------------------
// bounded_deque_store_unit
// Fixed-capacity deque held in a row of shifting cells; inserts and removes
// at either end, reads at head, tail or index through a tap chain.
// ----------------------------------------------------------------------------
// Insert, remove, no-op and flagged requests are registered in the cycle
//   after acceptance; a read loads the indexed word into the tap chain, which
//   moves it one cell per cycle toward cell zero, and is registered once it
//   reaches cell zero and the output is free. Throughput: 1 request per cycle
//   for non-read requests unless the output stalls, none during a read.
//   Reset clears count and control; cell contents are not cleared.
module bounded_deque_store_unit #(
    parameter int CAPACITY      = bdq_pkg::CAPACITY_DEF,
    parameter int ELEMENT_WIDTH = bdq_pkg::ELEMENT_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // element [31:0], position [39:32]
    input  logic [bdq_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // command [2:0]
    input  logic [bdq_pkg::CMD_W-1:0]      s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // read_value [31:0], count [40:32], zero pad [47:41]
    output logic [bdq_pkg::M_TDATA_W-1:0]  m_axis_tdata,
    // status [1:0]
    output logic [bdq_pkg::STATUS_W-1:0]   m_axis_tuser
);
    import bdq_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    t_state                   r_state;
    logic [CNT_W-1:0]         r_count;
    logic [IDX_W-1:0]         r_wait;
    logic                     r_m_valid;
    logic [VALUE_W-1:0]       r_m_value;
    logic [COUNT_W-1:0]       r_m_count;
    t_status                  r_m_status;

    logic                     s_fire;
    logic                     out_free;
    t_cmd                     cmd;
    logic [ELEM_W-1:0]        in_elem;
    logic [POS_W-1:0]         in_pos;
    logic [63:0]              elem_ext;
    logic [ELEMENT_WIDTH-1:0] elem_st;
    logic [63:0]              tap_ext;
    logic                     empty;
    logic                     full;
    logic [CNT_W-1:0]         n_count;
    t_status                  imm_status;
    logic                     start_read;
    logic [IDX_W-1:0]         rd_idx;
    t_cell_ctrl               ctrl;
    logic [IDX_W-1:0]         addr;

    logic [ELEMENT_WIDTH-1:0] cell_data [CAPACITY];
    logic [ELEMENT_WIDTH-1:0] cell_tap  [CAPACITY];

    assign out_free      = !r_m_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && out_free;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    assign cmd      = t_cmd'(s_axis_tuser);
    assign in_elem  = s_axis_tdata[ELEM_W-1:0];
    assign in_pos   = s_axis_tdata[ELEM_W+POS_W-1:ELEM_W];
    assign elem_ext = {32'd0, in_elem};
    assign elem_st  = elem_ext[ELEMENT_WIDTH-1:0];
    assign tap_ext  = 64'(cell_tap[0]);

    assign empty = (r_count == '0);
    assign full  = (r_count == CAP_CNT);

    always_comb begin
        n_count    = r_count;
        imm_status = ST_OK;
        start_read = 1'b0;
        rd_idx     = '0;
        ctrl       = '{op: CELL_HOLD, tap_load: 1'b0, tap_shift: 1'b0};
        addr       = '0;
        if (s_fire) begin
            unique case (cmd)
                CMD_INS_HEAD: begin
                    if (full) begin
                        imm_status = ST_FULL;
                    end else begin
                        ctrl.op = CELL_SHIFT_UP;
                        n_count = r_count + 1'b1;
                    end
                end
                CMD_INS_TAIL: begin
                    if (full) begin
                        imm_status = ST_FULL;
                    end else begin
                        ctrl.op = CELL_WRITE;
                        addr    = r_count[IDX_W-1:0];
                        n_count = r_count + 1'b1;
                    end
                end
                CMD_REM_HEAD: begin
                    if (empty) begin
                        imm_status = ST_EMPTY;
                    end else begin
                        ctrl.op = CELL_SHIFT_DOWN;
                        n_count = r_count - 1'b1;
                    end
                end
                CMD_REM_TAIL: begin
                    if (empty) begin
                        imm_status = ST_EMPTY;
                    end else begin
                        n_count = r_count - 1'b1;
                    end
                end
                CMD_RD_HEAD: begin
                    if (empty) begin
                        imm_status = ST_EMPTY;
                    end else begin
                        start_read = 1'b1;
                    end
                end
                CMD_RD_TAIL: begin
                    if (empty) begin
                        imm_status = ST_EMPTY;
                    end else begin
                        start_read = 1'b1;
                        rd_idx     = IDX_W'(r_count - 1'b1);
                    end
                end
                CMD_RD_INDEX: begin
                    if (empty) begin
                        imm_status = ST_EMPTY;
                    end else if (32'(in_pos) >= 32'(r_count)) begin
                        imm_status = ST_RANGE;
                    end else begin
                        start_read = 1'b1;
                        rd_idx     = IDX_W'(in_pos);
                    end
                end
                default: begin
                    n_count = r_count;
                end
            endcase
            if (start_read) begin
                ctrl.tap_load = 1'b1;
                addr          = rd_idx;
            end
        end
        if (r_state == S_READ) begin
            ctrl.tap_shift = (r_wait != '0);
        end
    end

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        logic [ELEMENT_WIDTH-1:0] left_data;
        logic [ELEMENT_WIDTH-1:0] right_data;
        logic [ELEMENT_WIDTH-1:0] right_tap;

        if (gi == 0) begin : g_first
            assign left_data = elem_st;
        end else begin : g_inner_l
            assign left_data = cell_data[gi-1];
        end
        if (gi == CAPACITY - 1) begin : g_last
            assign right_data = '0;
            assign right_tap  = '0;
        end else begin : g_inner_r
            assign right_data = cell_data[gi+1];
            assign right_tap  = cell_tap[gi+1];
        end

        bdq_cell #(
            .INDEX         (gi),
            .ELEMENT_WIDTH (ELEMENT_WIDTH),
            .IDX_W         (IDX_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (ctrl),
            .i_addr      (addr),
            .i_elem      (elem_st),
            .i_left      (left_data),
            .i_right     (right_data),
            .i_tap_right (right_tap),
            .o_data      (cell_data[gi]),
            .o_tap       (cell_tap[gi])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_wait    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (s_fire) begin
                        r_count <= n_count;
                        if (start_read) begin
                            r_state   <= S_READ;
                            r_wait    <= rd_idx;
                            r_m_valid <= 1'b0;
                        end else begin
                            r_m_valid  <= 1'b1;
                            r_m_value  <= '0;
                            r_m_count  <= COUNT_W'(n_count);
                            r_m_status <= imm_status;
                        end
                    end else if (m_axis_tready) begin
                        r_m_valid <= 1'b0;
                    end
                end
                S_READ: begin
                    if (r_wait != '0) begin
                        r_wait <= r_wait - 1'b1;
                        if (m_axis_tready) begin
                            r_m_valid <= 1'b0;
                        end
                    end else if (out_free) begin
                        r_state    <= S_IDLE;
                        r_m_valid  <= 1'b1;
                        r_m_value  <= tap_ext[VALUE_W-1:0];
                        r_m_count  <= COUNT_W'(r_count);
                        r_m_status <= ST_OK;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{(M_TDATA_W - VALUE_W - COUNT_W){1'b0}}, r_m_count, r_m_value};
    assign m_axis_tuser  = r_m_status;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_CNT)
        else $error("element count above capacity");

    a_no_accept_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !s_axis_tready)
        else $error("request taken while a read is in flight");

    a_head_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && cmd == CMD_INS_HEAD && !full) |=> (cell_data[0] == $past(elem_st)))
        else $error("head insert did not land in cell zero");

    a_count_hold_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |=> $stable(r_count))
        else $error("count changed during a read");

endmodule

/* rtl/core/bdq_cell.sv */
// ----------------------------------------------------------------------------
// bdq_cell
// One storage cell of the deque row: holds one element and one read tap,
// shifts data to either neighbor and passes read data toward cell zero.
// ----------------------------------------------------------------------------
module bdq_cell #(
    parameter int INDEX         = 0,
    parameter int ELEMENT_WIDTH = 32,
    parameter int IDX_W         = 8
) (
    input  logic                     i_clk,
    input  bdq_pkg::t_cell_ctrl      i_ctrl,
    input  logic [IDX_W-1:0]         i_addr,
    input  logic [ELEMENT_WIDTH-1:0] i_elem,
    input  logic [ELEMENT_WIDTH-1:0] i_left,
    input  logic [ELEMENT_WIDTH-1:0] i_right,
    input  logic [ELEMENT_WIDTH-1:0] i_tap_right,
    output logic [ELEMENT_WIDTH-1:0] o_data,
    output logic [ELEMENT_WIDTH-1:0] o_tap
);
    import bdq_pkg::*;

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic                     hit;
    logic [ELEMENT_WIDTH-1:0] r_data;
    logic [ELEMENT_WIDTH-1:0] r_tap;

    assign hit = (i_addr == MY_IDX);

    always_ff @(posedge i_clk) begin
        unique case (i_ctrl.op)
            CELL_HOLD:       r_data <= r_data;
            CELL_SHIFT_UP:   r_data <= i_left;
            CELL_SHIFT_DOWN: r_data <= i_right;
            CELL_WRITE: begin
                if (hit) begin
                    r_data <= i_elem;
                end
            end
            default:         r_data <= r_data;
        endcase
        if (i_ctrl.tap_load) begin
            r_tap <= hit ? r_data : i_tap_right;
        end else if (i_ctrl.tap_shift) begin
            r_tap <= i_tap_right;
        end
    end

    assign o_data = r_data;
    assign o_tap  = r_tap;

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for bounded_deque_store_unit. A directed table covers
// the empty list, the extreme element words, every command and the range
// errors. Random traffic then sweeps the list from empty to full and back
// under varying sender and receiver idling. Each result is compared with
// its row's typed value, if any, or else a local ring-buffer predictor of the list.
// ----------------------------------------------------------------------------
module testbench;
    import bdq_pkg::*;

    localparam int CAP              = CAPACITY_DEF;
    localparam int STAGE_ITEMS      = 610;
    localparam int HOLD_AT_ITEM     = 150;
    localparam int LONG_HOLD_CYCLES = 600;
    localparam int END_CYCLES       = 2 * (CAP + 2);
    localparam int EDGE_ITEMS       = 12;
    localparam int MIX_ITEMS        = 120;
    localparam int N_DIRECTED       = 26;

    typedef struct {
        logic [VALUE_W-1:0] read_value;
        logic [COUNT_W-1:0] count;
        t_status            status;
    } t_deque_result;

    typedef struct {
        t_cmd               cmd;
        logic [ELEM_W-1:0]  elem;
        logic [POS_W-1:0]   pos;
        bit                 typed;
        t_deque_result      want;
    } t_directed_row;

    typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIX} t_traffic_mode;

    logic                 i_clk;
    logic                 i_rst_n       = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // element [31:0], position [39:32]
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    // command [2:0]
    logic [CMD_W-1:0]     s_axis_tuser  = CMD_NOP;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // read_value [31:0], count [40:32], zero pad [47:41]
    logic [M_TDATA_W-1:0] m_axis_tdata;
    // status [1:0]
    logic [STATUS_W-1:0]  m_axis_tuser;

    logic [ELEM_W-1:0] ring_words [CAP];
    int                ring_head  = 0;
    int                ring_count = 0;

    t_deque_result pending_results [$];
    t_deque_result oldest_expected;
    int            errors = 0;
    int            tx_idle_pct = 14;
    int            rx_idle_pct = 75;
    int            long_hold_requests = 0;
    int            long_hold_served   = 0;
    int            hold_left          = 0;

    t_directed_row directed_rows [N_DIRECTED] = '{
        '{CMD_RD_HEAD,  32'h0000_0000, 8'h00, 1'b1, '{32'h0, 9'd0, ST_EMPTY}},
        '{CMD_RD_TAIL,  32'hFFFF_FFFF, 8'hFF, 1'b1, '{32'h0, 9'd0, ST_EMPTY}},
        '{CMD_RD_INDEX, 32'h0000_0000, 8'h00, 1'b1, '{32'h0, 9'd0, ST_EMPTY}},
        '{CMD_REM_HEAD, 32'h0000_0000, 8'h00, 1'b1, '{32'h0, 9'd0, ST_EMPTY}},
        '{CMD_REM_TAIL, 32'hFFFF_FFFF, 8'hFF, 1'b1, '{32'h0, 9'd0, ST_EMPTY}},
        '{CMD_NOP,      32'hFFFF_FFFF, 8'hFF, 1'b1, '{32'h0, 9'd0, ST_OK}},
        '{CMD_INS_TAIL, 32'hFFFF_FFFF, 8'hFF, 1'b1, '{32'h0, 9'd1, ST_OK}},
        '{CMD_INS_HEAD, 32'h0000_0000, 8'h00, 1'b1, '{32'h0, 9'd2, ST_OK}},
        '{CMD_INS_TAIL, 32'hA5A5_5A5A, 8'h55, 1'b0, '{32'h0, 9'd0, ST_OK}},
        '{CMD_INS_HEAD, 32'h8000_0001, 8'hAA, 1'b0, '{32'h0, 9'd0, ST_OK}},
        '{CMD_RD_HEAD,  32'h0000_0000, 8'h00, 1'b0, '{32'h0, 9'd0, ST_OK}},
        '{CMD_RD_TAIL,  32'h0000_0000, 8'h00, 1'b0, '{32'h0, 9'd0, ST_OK}},
        '{CMD_RD_INDEX, 32'h0000_0000, 8'h00, 1'b0, '{32'h0, 9'd0, ST_OK}},
        '{CMD_RD_INDEX, 32'h0000_0000, 8'h02, 1'b0, '{32'h0, 9'd0, ST_OK}},
        '{CMD_RD_INDEX, 32'h0000_0000, 8'h03, 1'b0, '{32'h0, 9'd0, ST_OK}},
        '{CMD_RD_INDEX, 32'h0000_0000, 8'h04, 1'b1, '{32'h0, 9'd4, ST_RANGE}},
        '{CMD_RD_INDEX, 32'hFFFF_FFFF, 8'hFF, 1'b1, '{32'h0, 9'd4, ST_RANGE}},
        '{CMD_REM_HEAD, 32'h0000_0000, 8'h00, 1'b0, '{32'h0, 9'd0, ST_OK}},
        '{CMD_RD_HEAD,  32'h0000_0000, 8'h00, 1'b0, '{32'h0, 9'd0, ST_OK}},
        '{CMD_REM_TAIL, 32'h0000_0000, 8'h00, 1'b0, '{32'h0, 9'd0, ST_OK}},
        '{CMD_RD_TAIL,  32'h0000_0000, 8'h00, 1'b0, '{32'h0, 9'd0, ST_OK}},
        '{CMD_RD_INDEX, 32'h0000_0000, 8'h01, 1'b0, '{32'h0, 9'd0, ST_OK}},
        '{CMD_NOP,      32'hFFFF_FFFF, 8'hFF, 1'b0, '{32'h0, 9'd0, ST_OK}},
        '{CMD_REM_HEAD, 32'h0000_0000, 8'h00, 1'b0, '{32'h0, 9'd0, ST_OK}},
        '{CMD_REM_TAIL, 32'h0000_0000, 8'h00, 1'b0, '{32'h0, 9'd0, ST_OK}},
        '{CMD_RD_TAIL,  32'h0000_0000, 8'h00, 1'b1, '{32'h0, 9'd0, ST_EMPTY}}
    };

    bounded_deque_store_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #10_000_000;
        $display("FAIL bounded_deque_store_unit");
        $finish;
    end

    function automatic int ring_slot(int offset);
        return (ring_head + offset) % CAP;
    endfunction

    function automatic t_deque_result apply_command(t_cmd cmd, logic [ELEM_W-1:0] elem,
                                                    logic [POS_W-1:0] pos);
        t_deque_result res;
        res.read_value = '0;
        res.status     = ST_OK;
        case (cmd)
            CMD_INS_HEAD: begin
                if (ring_count >= CAP) begin
                    res.status = ST_FULL;
                end else begin
                    ring_head = (ring_head + CAP - 1) % CAP;
                    ring_words[ring_head] = elem;
                    ring_count++;
                end
            end
            CMD_INS_TAIL: begin
                if (ring_count >= CAP) begin
                    res.status = ST_FULL;
                end else begin
                    ring_words[ring_slot(ring_count)] = elem;
                    ring_count++;
                end
            end
            CMD_REM_HEAD: begin
                if (ring_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    ring_head = ring_slot(1);
                    ring_count--;
                end
            end
            CMD_REM_TAIL: begin
                if (ring_count == 0) res.status = ST_EMPTY;
                else ring_count--;
            end
            CMD_RD_HEAD: begin
                if (ring_count == 0) res.status = ST_EMPTY;
                else res.read_value = ring_words[ring_slot(0)];
            end
            CMD_RD_TAIL: begin
                if (ring_count == 0) res.status = ST_EMPTY;
                else res.read_value = ring_words[ring_slot(ring_count - 1)];
            end
            CMD_RD_INDEX: begin
                if (ring_count == 0) res.status = ST_EMPTY;
                else if (int'(pos) >= ring_count) res.status = ST_RANGE;
                else res.read_value = ring_words[ring_slot(int'(pos))];
            end
            default: begin
            end
        endcase
        res.count = COUNT_W'(ring_count);
        return res;
    endfunction

    task automatic issue_request(input t_cmd cmd, input logic [ELEM_W-1:0] elem,
                                 input logic [POS_W-1:0] pos, input bit typed,
                                 input t_deque_result typed_result);
        t_deque_result predicted;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {pos, elem};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = apply_command(cmd, elem, pos);
        pending_results.push_back(typed ? typed_result : predicted);
    endtask

    task automatic wait_results();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // receiver: random idling, plus a long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else if (long_hold_served != long_hold_requests) begin
                long_hold_served++;
                hold_left = LONG_HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result: read_value %h count %0d status %0d",
                       m_axis_tdata[31:0], m_axis_tdata[40:32], m_axis_tuser);
                errors++;
            end else begin
                oldest_expected = pending_results.pop_front();
                if (m_axis_tdata[31:0] !== oldest_expected.read_value) begin
                    $error("read_value: expected %h, got %h",
                           oldest_expected.read_value, m_axis_tdata[31:0]);
                    errors++;
                end
                if (m_axis_tdata[40:32] !== oldest_expected.count) begin
                    $error("count: expected %0d, got %0d",
                           oldest_expected.count, m_axis_tdata[40:32]);
                    errors++;
                end
                if (m_axis_tuser !== oldest_expected.status) begin
                    $error("status: expected %0d, got %0d",
                           oldest_expected.status, m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    initial begin
        t_traffic_mode     mode;
        t_cmd              cmd;
        logic [ELEM_W-1:0] elem;
        logic [POS_W-1:0]  pos;
        t_deque_result     no_result;
        int                edge_items;
        int                r;
        int                ins_lim;
        int                rem_lim;
        int                rd_lim;

        no_result.read_value = '0;
        no_result.count      = '0;
        no_result.status     = ST_OK;
        mode       = MODE_FILL;
        edge_items = 0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i]) begin
            issue_request(directed_rows[i].cmd, directed_rows[i].elem, directed_rows[i].pos,
                          directed_rows[i].typed, directed_rows[i].want);
        end

        for (int stage = 0; stage < 3; stage++) begin
            wait_results();
            tx_idle_pct = (stage == 0) ? 14 : (stage == 1) ? 75 : 0;
            rx_idle_pct = (stage == 0) ? 75 : (stage == 1) ? 14 : 0;
            for (int k = 0; k < STAGE_ITEMS; k++) begin
                if (k == HOLD_AT_ITEM) long_hold_requests++;

                case (mode)
                    MODE_FILL: begin
                        if (ring_count == CAP && ++edge_items > EDGE_ITEMS) begin
                            mode = MODE_DRAIN;
                            edge_items = 0;
                        end
                    end
                    MODE_DRAIN: begin
                        if (ring_count == 0 && ++edge_items > EDGE_ITEMS) begin
                            mode = MODE_MIX;
                            edge_items = 0;
                        end
                    end
                    default: begin
                        if (++edge_items > MIX_ITEMS) begin
                            mode = MODE_FILL;
                            edge_items = 0;
                        end
                    end
                endcase

                ins_lim = (mode == MODE_FILL) ? 70 : (mode == MODE_DRAIN) ? 8 : 36;
                rem_lim = (mode == MODE_FILL) ? 78 : (mode == MODE_DRAIN) ? 72 : 70;
                rd_lim  = 96;
                r = $urandom_range(99);
                if (r < ins_lim) begin
                    cmd = ($urandom_range(1) != 0) ? CMD_INS_TAIL : CMD_INS_HEAD;
                end else if (r < rem_lim) begin
                    cmd = ($urandom_range(1) != 0) ? CMD_REM_TAIL : CMD_REM_HEAD;
                end else if (r < rd_lim) begin
                    case ($urandom_range(2))
                        0: cmd = CMD_RD_HEAD;
                        1: cmd = CMD_RD_TAIL;
                        default: cmd = CMD_RD_INDEX;
                    endcase
                end else begin
                    cmd = CMD_NOP;
                end

                elem = $urandom;
                if (ring_count != 0 && $urandom_range(3) != 0)
                    pos = POS_W'($urandom_range(ring_count - 1));
                else
                    pos = POS_W'($urandom_range(255));

                issue_request(cmd, elem, pos, 1'b0, no_result);
            end
        end

        wait_results();
        repeat (END_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("PASS bounded_deque_store_unit");
        end else begin
            $display("FAIL bounded_deque_store_unit");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/core/bdq_pkg.sv
rtl/core/bdq_cell.sv
rtl/core/bounded_deque_store_unit.sv
sim/testbench.sv
